### rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types and codes of the bencode stream tokenizer
// Event codes, error codes, the framing characters of the encoding and the
// result word that travels from the parser core to the output buffer.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Event codes carried in event_res.
  localparam logic [2:0] EV_LIST_START = 3'd0;
  localparam logic [2:0] EV_LIST_END   = 3'd1;
  localparam logic [2:0] EV_DICT_START = 3'd2;
  localparam logic [2:0] EV_DICT_END   = 3'd3;
  localparam logic [2:0] EV_INTEGER    = 3'd4;
  localparam logic [2:0] EV_STR_START  = 3'd5;
  localparam logic [2:0] EV_STR_BYTE   = 3'd6;
  localparam logic [2:0] EV_ERROR      = 3'd7;

  // Error codes carried in error_code.
  localparam logic [2:0] ERR_LEAD  = 3'd0;
  localparam logic [2:0] ERR_INT   = 3'd1;
  localparam logic [2:0] ERR_LEN   = 3'd2;
  localparam logic [2:0] ERR_DEEP  = 3'd3;
  localparam logic [2:0] ERR_TRUNC = 3'd4;

  // Framing characters.
  localparam logic [7:0] CH_INT    = 8'h69;  // 'i'
  localparam logic [7:0] CH_LIST   = 8'h6C;  // 'l'
  localparam logic [7:0] CH_DICT   = 8'h64;  // 'd'
  localparam logic [7:0] CH_END    = 8'h65;  // 'e'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

  // Magnitude limits of a signed 64-bit integer, widened for the
  // multiply-accumulate result.
  localparam logic [67:0] INT_LIMIT_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] INT_LIMIT_NEG = 68'h0_8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0]         event_res;
    logic               is_key;
    logic [7:0]         payload_byte;
    logic signed [63:0] integer_value;
    logic [31:0]        string_length;
    logic               last_of_string;
    logic [2:0]         error_code;
    logic               last_result;
  } result_t;

  // Everything one byte produces: zero, one or two result words.
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } step_res_t;

endpackage

### rtl/bencode_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// bencode_stream_tokenizer: streaming bencode parser with event output
// Registers each input word, decodes it against the parser state and
// queues its events in a two-slot result register.
// ----------------------------------------------------------------------------
// The tokenizer takes a bencoded message one byte per input word and
// returns a stream of event words: list and dictionary start and end,
// decoded integers, errors, and strings as a string_start word carrying the
// declared length followed by one string_byte word per payload byte, with
// is_key set on the strings of dictionary keys. A byte is first captured
// in an input register, then decoded against the parser state as soon as
// the result register can take its words, and written into the two-slot
// result register. The block sustains one input word per cycle while the
// result side keeps up; a byte that yields two words (its own event plus a
// truncation error on the final byte) holds the input side until the first
// of them is taken, as the result register hands out one word per cycle
// while result_ready is high. Bytes that yield no event (number digits,
// skipped bytes, anything after a finished value or an error) are consumed
// and produce nothing. last_result marks the final word of each byte.
// Raising end_of_message on a byte ends the message: the parser reports a
// truncation error if the top value was left open and then starts afresh.
// STACK_DEPTH bounds the nesting of containers and LENGTH_BITS bounds the
// declared string length; integers cover the full signed 64-bit range.
module bencode_stream_tokenizer import bst_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_message,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [2:0]         event_res,
  output logic               is_key,
  output logic [7:0]         payload_byte,
  output logic signed [63:0] integer_value,
  output logic [31:0]        string_length,
  output logic               last_of_string,
  output logic [2:0]         error_code,
  output logic               last_result
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eom_q;

  logic       can_load;
  logic       fire;
  step_res_t  step_res;
  result_t    head;

  // A registered byte is decoded as soon as the result register can take
  // everything it may produce; the input register refills in that cycle.
  assign fire       = in_valid_q && can_load;
  assign data_ready = !in_valid_q || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (data_valid && data_ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      in_byte_q <= data_byte;
      in_eom_q  <= end_of_message;
    end
  end

  bst_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (fire),
    .data_byte      (in_byte_q),
    .end_of_message (in_eom_q),
    .res            (step_res)
  );

  bst_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .res        (step_res),
    .can_load   (can_load),
    .head       (head),
    .head_valid (result_valid),
    .head_ready (result_ready)
  );

  assign event_res      = head.event_res;
  assign is_key         = head.is_key;
  assign payload_byte   = head.payload_byte;
  assign integer_value  = head.integer_value;
  assign string_length  = head.string_length;
  assign last_of_string = head.last_of_string;
  assign error_code     = head.error_code;
  assign last_result    = head.last_result;

  // A word that is not the last of its byte always has a successor waiting.
  a_pending_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last_result |=> result_valid)
    else $error("second word of a byte was lost");

  // With the result register empty, a held byte is decoded at once.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !result_valid |-> data_ready)
    else $error("input stalled with an empty result register");

  // A word that waits keeps its fields until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(head))
    else $error("waiting result word changed");

endmodule

### rtl/bst_core.sv
// ----------------------------------------------------------------------------
// bst_core: parser state and per-byte decode
// Holds the parse mode, the container stack and the number accumulator, and
// turns one registered byte into its result words combinationally.
// ----------------------------------------------------------------------------
module bst_core import bst_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic [7:0] data_byte,
  input  logic      end_of_message,
  output step_res_t res
);

  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [67:0] LEN_LIMIT = (68'd1 << LENGTH_BITS) - 68'd1;

  typedef enum logic [1:0] {
    MODE_VALUE,
    MODE_INT,
    MODE_LEN,
    MODE_BODY
  } mode_t;

  mode_t                   mode, mode_next;
  logic [STACK_DEPTH-1:0]  stack;
  logic [DW-1:0]           depth, depth_next, depth_m1;
  logic                    value_due, value_due_next;
  logic [63:0]             acc, acc_next;
  logic                    neg, neg_next;
  logic                    digit_seen, digit_seen_next;
  logic                    prefix_ended, prefix_ended_next;
  logic [LENGTH_BITS-1:0]  remaining, remaining_next;
  logic                    done, done_next;

  logic                    push_en, push_kind;
  logic                    is_digit, top_kind, top_dict, in_key;
  logic [3:0]              digit;
  logic [67:0]             prod;
  logic [63:0]             int_val;
  logic                    finish, raise;
  logic [2:0]              raise_code;
  logic                    ev_v, trunc_v;
  result_t                 ev, trunc;

  assign depth_m1 = depth - DW'(1);
  assign top_kind = stack[depth_m1[IDX_W-1:0]];
  assign top_dict = (depth != '0) && top_kind;
  assign in_key   = top_dict && !value_due;
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit    = data_byte[3:0];
  // acc * 10 + digit as two shifted copies and the digit.
  assign prod     = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, digit};
  assign int_val  = neg ? (64'd0 - acc) : acc;

  always_comb begin
    mode_next         = mode;
    depth_next        = depth;
    value_due_next    = value_due;
    acc_next          = acc;
    neg_next          = neg;
    digit_seen_next   = digit_seen;
    prefix_ended_next = prefix_ended;
    remaining_next    = remaining;
    done_next         = done;
    push_en           = 1'b0;
    push_kind         = 1'b0;
    finish            = 1'b0;
    raise             = 1'b0;
    raise_code        = ERR_LEAD;
    ev_v              = 1'b0;
    ev                = '0;

    if (!done) begin
      unique case (mode)
        MODE_VALUE: begin
          if ((depth != '0) && (data_byte == CH_END) && (!top_dict || !value_due)) begin
            depth_next     = depth_m1;
            value_due_next = 1'b0;
            if (depth_m1 == '0) begin
              done_next = 1'b1;
            end
            ev_v         = 1'b1;
            ev.event_res = top_kind ? EV_DICT_END : EV_LIST_END;
          end else if (is_digit) begin
            mode_next         = MODE_LEN;
            acc_next          = {60'd0, digit};
            digit_seen_next   = 1'b1;
            prefix_ended_next = 1'b0;
          end else if (data_byte == CH_MINUS) begin
            raise      = 1'b1;
            raise_code = ERR_LEN;
          end else if (in_key) begin
            raise      = 1'b1;
            raise_code = ERR_LEAD;
          end else if (data_byte == CH_INT) begin
            mode_next         = MODE_INT;
            acc_next          = '0;
            neg_next          = 1'b0;
            digit_seen_next   = 1'b0;
            prefix_ended_next = 1'b0;
          end else if ((data_byte == CH_LIST) || (data_byte == CH_DICT)) begin
            if (depth >= DW'(STACK_DEPTH)) begin
              raise      = 1'b1;
              raise_code = ERR_DEEP;
            end else begin
              push_en        = 1'b1;
              push_kind      = (data_byte == CH_DICT);
              depth_next     = depth + DW'(1);
              value_due_next = 1'b0;
              ev_v           = 1'b1;
              ev.event_res   = (data_byte == CH_DICT) ? EV_DICT_START : EV_LIST_START;
            end
          end else begin
            raise      = 1'b1;
            raise_code = ERR_LEAD;
          end
        end

        MODE_INT: begin
          if (data_byte == CH_END) begin
            if (!digit_seen) begin
              raise      = 1'b1;
              raise_code = ERR_INT;
            end else begin
              ev_v             = 1'b1;
              ev.event_res     = EV_INTEGER;
              ev.integer_value = int_val;
              finish           = 1'b1;
            end
          end else if (!prefix_ended) begin
            if (is_digit) begin
              if (prod > (neg ? INT_LIMIT_NEG : INT_LIMIT_POS)) begin
                raise      = 1'b1;
                raise_code = ERR_INT;
              end else begin
                acc_next        = prod[63:0];
                digit_seen_next = 1'b1;
              end
            end else if (!digit_seen) begin
              if ((data_byte == CH_MINUS) && !neg) begin
                neg_next = 1'b1;
              end else begin
                raise      = 1'b1;
                raise_code = ERR_INT;
              end
            end else begin
              prefix_ended_next = 1'b1;
            end
          end
        end

        MODE_LEN: begin
          if (data_byte == CH_COLON) begin
            ev_v              = 1'b1;
            ev.event_res      = EV_STR_START;
            ev.is_key         = in_key;
            ev.string_length  = acc[31:0];
            ev.last_of_string = (acc == '0);
            if (acc == '0) begin
              finish = 1'b1;
            end else begin
              remaining_next = acc[LENGTH_BITS-1:0];
              mode_next      = MODE_BODY;
            end
          end else if (!prefix_ended) begin
            if (is_digit) begin
              if (prod > LEN_LIMIT) begin
                raise      = 1'b1;
                raise_code = ERR_LEN;
              end else begin
                acc_next = prod[63:0];
              end
            end else begin
              prefix_ended_next = 1'b1;
            end
          end
        end

        MODE_BODY: begin
          ev_v              = 1'b1;
          ev.event_res      = EV_STR_BYTE;
          ev.is_key         = in_key;
          ev.payload_byte   = data_byte;
          ev.last_of_string = (remaining <= LENGTH_BITS'(1));
          if (remaining <= LENGTH_BITS'(1)) begin
            remaining_next = '0;
            finish         = 1'b1;
          end else begin
            remaining_next = remaining - LENGTH_BITS'(1);
          end
        end

        default: begin
          mode_next = MODE_VALUE;
        end
      endcase
    end

    // A finished scalar completes the message at top level, flips the key/value
    // phase of an enclosing dictionary and leaves an enclosing list as it is.
    if (finish) begin
      mode_next = MODE_VALUE;
      if (depth == '0) begin
        done_next = 1'b1;
      end else if (top_kind) begin
        value_due_next = !value_due;
      end
    end

    if (raise) begin
      ev_v          = 1'b1;
      ev            = '0;
      ev.event_res  = EV_ERROR;
      ev.error_code = raise_code;
      done_next     = 1'b1;
      mode_next     = MODE_VALUE;
    end

    trunc            = '0;
    trunc.event_res  = EV_ERROR;
    trunc.error_code = ERR_TRUNC;
    trunc_v          = end_of_message && !done_next;

    // The final byte of a message returns the parser to its reset state.
    if (end_of_message) begin
      mode_next         = MODE_VALUE;
      depth_next        = '0;
      value_due_next    = 1'b0;
      acc_next          = '0;
      neg_next          = 1'b0;
      digit_seen_next   = 1'b0;
      prefix_ended_next = 1'b0;
      remaining_next    = '0;
      done_next         = 1'b0;
    end
  end

  always_comb begin
    res                    = '0;
    res.n                  = {1'b0, ev_v} + {1'b0, trunc_v};
    res.first              = ev_v ? ev : trunc;
    res.first.last_result  = !(ev_v && trunc_v);
    res.second             = trunc;
    res.second.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_VALUE;
      depth        <= '0;
      value_due    <= 1'b0;
      acc          <= '0;
      neg          <= 1'b0;
      digit_seen   <= 1'b0;
      prefix_ended <= 1'b0;
      remaining    <= '0;
      done         <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      depth        <= depth_next;
      value_due    <= value_due_next;
      acc          <= acc_next;
      neg          <= neg_next;
      digit_seen   <= digit_seen_next;
      prefix_ended <= prefix_ended_next;
      remaining    <= remaining_next;
      done         <= done_next;
    end
  end

  // Container kinds: 0 list, 1 dictionary. Entries above the depth are
  // never used, so the stack needs no reset.
  always_ff @(posedge clk) begin
    if (step && push_en) begin
      stack[depth[IDX_W-1:0]] <= push_kind;
    end
  end

  a_depth_bounded: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("nesting depth beyond stack size");

  a_eom_resets: assert property (@(posedge clk) disable iff (rst)
    step && end_of_message |=> (depth == '0) && (mode == MODE_VALUE) && !done)
    else $error("parser not back at start after final byte");

  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    step && !end_of_message && (res.n != 2'd0) && (res.first.event_res == EV_ERROR)
    |=> done)
    else $error("parser kept going after an error");

endmodule

### rtl/bst_out_buf.sv
// ----------------------------------------------------------------------------
// bst_out_buf: two-slot result register
// Takes all result words of one byte at once and hands them out one word
// per cycle in order while head_ready is high.
// ----------------------------------------------------------------------------
module bst_out_buf import bst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  step_res_t res,
  output logic      can_load,
  output result_t   head,
  output logic      head_valid,
  input  logic      head_ready
);

  logic [1:0] count;
  result_t    slot0, slot1;
  logic       take;

  assign take       = (count != 2'd0) && head_ready;
  assign can_load   = (count == 2'd0) || ((count == 2'd1) && head_ready);
  assign head       = slot0;
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load && (res.n != 2'd0)) begin
      count <= res.n;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && (res.n != 2'd0)) begin
      slot0 <= res.first;
      slot1 <= res.second;
    end else if (take && (count == 2'd2)) begin
      slot0 <= slot1;
    end
  end

endmodule
